/* sv/radio_frame_checksum_checker_top_assert.svh */
// assertion macros shared by the checksum checker modules
// no dependencies; each macro takes a label, clock, reset and two expressions
`ifndef RADIO_FRAME_CHECKSUM_CHECKER_TOP_ASSERT_SVH
`define RADIO_FRAME_CHECKSUM_CHECKER_TOP_ASSERT_SVH

// same-cycle implication
`define RFCC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfcc assertion failed");

// next-cycle implication
`define RFCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfcc assertion failed");

`endif

/* sv/rfcc_pkg.sv */
// types, constants and helpers for the radio frame checksum checker
// no dependencies
package rfcc_pkg;

   localparam int FRAME_BYTES_DEFAULT = 32;
   localparam int HELD_W  = 6;
   localparam int GOOD_W  = 16;
   localparam int BITS_W  = 24;
   localparam logic [7:0] START_RESET = 8'hE5;
   localparam logic [GOOD_W-1:0] GOOD_MAX = 16'hFFFF;
   localparam logic [BITS_W-1:0] BITS_MAX = 24'hFFFFFF;

   typedef enum logic {
      KIND_BYTE = 1'b0,
      KIND_TICK = 1'b1
   } req_kind_type;

   typedef enum logic {
      REPORT_VERDICT = 1'b0,
      REPORT_RATE    = 1'b1
   } rsp_kind_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic              report_kind;
      logic              checksum_ok;
      logic [BITS_W-1:0] good_bits;
   } rsp_word_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } core_result_type;

   // ones-complement add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] word);
      logic [16:0] s;
      logic [16:0] t;
      s = {1'b0, acc} + {1'b0, word};
      t = {1'b0, s[15:0]} + {16'h0, s[16]};
      return t[15:0];
   endfunction

endpackage

/* sv/rfcc_core.sv */
// frame tracker, checksum accumulator and good frame counter
// depends on rfcc_pkg and the assertion macro header
`include "radio_frame_checksum_checker_top_assert.svh"

module rfcc_core import rfcc_pkg::*; #(
   parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write,
   input  logic [7:0]      csr_data,
   input  logic            advance,
   input  req_word_type    word,
   output core_result_type result
);

   localparam logic [HELD_W-1:0] LAST_SUM = HELD_W'(FRAME_BYTES - 2);
   localparam logic [HELD_W-1:0] LAST_IDX = HELD_W'(FRAME_BYTES - 1);
   localparam logic [31:0]       WORD_BITS = 32'(FRAME_BYTES * 8);
   localparam bit                ODD_FRAME = (FRAME_BYTES % 2) == 1;

   logic [7:0]        start_ff, start_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic [7:0]        low_ff, low_in;
   logic [15:0]       sum_ff, sum_in;
   logic [7:0]        chk_ff, chk_in;
   logic [GOOD_W-1:0] good_ff, good_in;

   logic [31:0]       prod;
   logic [15:0]       swapped;
   logic              match;

   assign prod    = 32'(good_ff) * WORD_BITS;
   assign swapped = {sum_ff[7:0], sum_ff[15:8]};
   assign match   = swapped == {word.data_byte, chk_ff};
   assign start_in = csr_write ? csr_data : start_ff;

   always_comb begin
      held_in = held_ff;
      low_in  = low_ff;
      sum_in  = sum_ff;
      chk_in  = chk_ff;
      good_in = good_ff;
      result  = '0;
      if (advance) begin
         if (word.kind == KIND_TICK) begin
            result.valid            = 1'b1;
            result.word.report_kind = REPORT_RATE;
            result.word.good_bits   = (prod > 32'(BITS_MAX)) ? BITS_MAX : prod[BITS_W-1:0];
            good_in                 = '0;
         end else if (held_ff == '0) begin
            if (word.data_byte == start_ff) begin
               low_in  = word.data_byte;
               sum_in  = '0;
               held_in = HELD_W'(1);
            end
         end else if (held_ff < LAST_SUM) begin
            if (held_ff[0]) begin
               sum_in = oc_add(sum_ff, {word.data_byte, low_ff});
            end else begin
               low_in = word.data_byte;
            end
            held_in = held_ff + HELD_W'(1);
         end else if (held_ff == LAST_SUM) begin
            if (ODD_FRAME) begin
               sum_in = oc_add(sum_ff, {8'h00, low_ff});
            end
            chk_in  = word.data_byte;
            held_in = held_ff + HELD_W'(1);
         end else begin
            result.valid            = 1'b1;
            result.word.report_kind = REPORT_VERDICT;
            result.word.checksum_ok = match;
            if (match && good_ff != GOOD_MAX) begin
               good_in = good_ff + GOOD_W'(1);
            end
            held_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RESET;
         held_ff  <= '0;
         low_ff   <= '0;
         sum_ff   <= '0;
         chk_ff   <= '0;
         good_ff  <= '0;
      end else begin
         start_ff <= start_in;
         held_ff  <= held_in;
         low_ff   <= low_in;
         sum_ff   <= sum_in;
         chk_ff   <= chk_in;
         good_ff  <= good_in;
      end
   end

   `RFCC_ASSERT_NOW(a_held_range, clock, reset, 1'b1, held_ff <= LAST_IDX)
   `RFCC_ASSERT_NEXT(a_verdict_rehunts, clock, reset,
      result.valid && result.word.report_kind == REPORT_VERDICT, held_ff == '0)
   `RFCC_ASSERT_NEXT(a_tick_clears, clock, reset,
      advance && word.kind == KIND_TICK, good_ff == '0)
   `RFCC_ASSERT_NEXT(a_idle_holds, clock, reset, !advance, $stable(held_ff) && $stable(sum_ff))

endmodule

/* sv/rfcc_out_fifo.sv */
// two-entry result queue that decouples the core from the response stall
// depends on rfcc_pkg and the assertion macro header
`include "radio_frame_checksum_checker_top_assert.svh"

module rfcc_out_fifo import rfcc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  core_result_type push,
   output logic            full,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_word_type    rsp_word
);

   rsp_word_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign full      = count_ff == 2'd2;
   assign rsp_valid = count_ff != 2'd0;
   assign rsp_word  = slot_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = push.valid ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push.valid) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `RFCC_ASSERT_NOW(a_no_push_full, clock, reset, push.valid, !full)
   `RFCC_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff != 2'd3)
   `RFCC_ASSERT_NEXT(a_push_shows, clock, reset, push.valid, rsp_valid)

endmodule

/* sv/radio_frame_checksum_checker_top.sv */
// radio frame checksum checker, top level
// usage: req_ carries one word per received byte or window tick (kind 1).
// a byte stream is hunted for start_code; a frame of FRAME_BYTES bytes then
// gets a ones-complement checksum verdict on rsp_ (report_kind 0).
// a tick returns the good bits of the window (report_kind 1) and clears it.
// bytes that only advance a frame give no rsp_ word.
// csr_ writes start_code; csr_ready is always high, write only while idle.
// throughput: one req_ word per cycle while req_stall is low, set by the
// combinational update of the frame state and 16-bit end-around-carry add.
// a result reaches rsp_ through the input register and then the
// two-entry result queue.
// when rsp_stall holds, the queue fills after two results and req_stall
// rises; no word is lost.
// reset clears frame state, the good count and the queue, and restores
// start_code to 0xE5.
// depends on rfcc_pkg, rfcc_core and rfcc_out_fifo
module radio_frame_checksum_checker_top import rfcc_pkg::*; #(
   parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_data
);

   logic            s1_valid_ff, s1_valid_in;
   req_word_type    s1_word_ff;
   logic            full;
   logic            advance;
   logic            accept;
   core_result_type result;

   assign csr_ready = 1'b1;
   assign advance   = s1_valid_ff && !full;
   assign req_stall = s1_valid_ff && full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   rfcc_core #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .advance   (advance),
      .word      (s1_word_ff),
      .result    (result)
   );

   rfcc_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (result),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
